>>> rtl/crp_pkg.sv
// Shared types and constants of the color ramp interpolator.
// Depends on nothing; every other file in rtl imports it.
package crp_pkg;

   localparam int POS_W      = 16;
   localparam int CHAN_W     = 16;
   localparam int NUM_W      = 32;
   localparam int COUNT_W    = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_FIRST = 3'd1;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd2;
   localparam logic [COUNT_W-1:0] COUNT_MIN   = 3'd2;

   // Channel order inside a packed color, highest first as in the stop word.
   localparam int CH_RED   = 2;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 0;

   typedef logic [CHAN_W-1:0] chan_type;
   typedef chan_type [2:0] color_type;
   typedef logic [NUM_W-1:0] num_type;

   typedef struct packed {
      logic signed [POS_W-1:0] pos;
      color_type               color;
   } stop_type;

   // Operands of the blend: colors of both stops, their weights and the divisor.
   typedef struct packed {
      color_type         lo;
      color_type         hi;
      logic [POS_W-1:0]  wlo;
      logic [POS_W-1:0]  whi;
      logic [POS_W-1:0]  div;
   } blend_type;

   // Rounded numerators of all three channels and the shared divisor.
   typedef struct packed {
      num_type [2:0]     num;
      logic [POS_W-1:0]  div;
   } frac_type;

endpackage

>>> rtl/crp_select.sv
// Stop selection: finds the enclosing stop pair and forms the blend weights.
// Two register stages. Depends on crp_pkg.
module crp_select #(
   parameter int NUM_STOPS = 6
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 in_valid,
   input  logic signed [crp_pkg::POS_W-1:0]     in_position,
   input  crp_pkg::stop_type [NUM_STOPS-1:0]    stops,
   input  logic [crp_pkg::COUNT_W-1:0]          stop_count,
   output logic                                 out_valid,
   output crp_pkg::blend_type                   out_blend
);
   import crp_pkg::*;

   localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(NUM_STOPS);

   typedef struct packed {
      stop_type                lo;
      stop_type                hi;
      logic signed [POS_W-1:0] pos;
      logic                    direct;
   } pick_type;

   logic [COUNT_W-1:0] count_eff;
   stop_type           last_stop;
   pick_type           pick_in, pick_ff;
   logic               pick_valid_ff;
   blend_type          blend_in, blend_ff;
   logic               blend_valid_ff;
   logic signed [POS_W:0] span_full, off_full;
   logic [POS_W-1:0]   span, off;

   always_comb begin
      if (stop_count < COUNT_MIN) begin
         count_eff = COUNT_MIN;
      end else if (stop_count > COUNT_MAX) begin
         count_eff = COUNT_MAX;
      end else begin
         count_eff = stop_count;
      end
   end

   always_comb begin
      last_stop = stops[0];
      for (int k = 0; k < NUM_STOPS; k++) begin
         if (COUNT_W'(k) == count_eff - COUNT_W'(1)) begin
            last_stop = stops[k];
         end
      end
   end

   // Later assignments win, so the lowest enclosing pair and the clamps take priority.
   always_comb begin
      pick_in.lo     = '0;
      pick_in.hi     = '0;
      pick_in.pos    = in_position;
      pick_in.direct = 1'b1;
      for (int i = NUM_STOPS - 2; i >= 0; i--) begin
         if (COUNT_W'(i + 1) < count_eff && stops[i].pos <= in_position &&
             in_position <= stops[i+1].pos) begin
            pick_in.lo     = stops[i];
            pick_in.hi     = stops[i+1];
            pick_in.direct = 1'b0;
         end
      end
      if (in_position >= last_stop.pos) begin
         pick_in.lo     = last_stop;
         pick_in.direct = 1'b1;
      end
      if (in_position <= stops[0].pos) begin
         pick_in.lo     = stops[0];
         pick_in.direct = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pick_valid_ff <= 1'b0;
      end else if (en) begin
         pick_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pick_ff <= pick_in;
      end
   end

   // A direct color or a zero-width pair passes the lower color through a divide by one.
   always_comb begin
      span_full = {pick_ff.hi.pos[POS_W-1], pick_ff.hi.pos} -
                  {pick_ff.lo.pos[POS_W-1], pick_ff.lo.pos};
      off_full  = {pick_ff.pos[POS_W-1], pick_ff.pos} -
                  {pick_ff.lo.pos[POS_W-1], pick_ff.lo.pos};
      span      = span_full[POS_W-1:0];
      off       = off_full[POS_W-1:0];
      blend_in.lo = pick_ff.lo.color;
      blend_in.hi = pick_ff.hi.color;
      if (pick_ff.direct || span == '0) begin
         blend_in.wlo = POS_W'(1);
         blend_in.whi = '0;
         blend_in.div = POS_W'(1);
      end else begin
         blend_in.wlo = span - off;
         blend_in.whi = off;
         blend_in.div = span;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_valid_ff <= 1'b0;
      end else if (en) begin
         blend_valid_ff <= pick_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         blend_ff <= blend_in;
      end
   end

   assign out_valid = blend_valid_ff;
   assign out_blend = blend_ff;

endmodule

>>> rtl/crp_mac.sv
// Weighted sum of the two stop colors plus the rounding term, per channel.
// Two register stages: products, then sum. Depends on crp_pkg.
module crp_mac (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  crp_pkg::blend_type  in_blend,
   output logic                out_valid,
   output crp_pkg::frac_type   out_frac
);
   import crp_pkg::*;

   num_type [2:0]    prod_lo_in, prod_hi_in, prod_lo_ff, prod_hi_ff;
   logic [POS_W-1:0] div_ff;
   logic             prod_valid_ff;
   frac_type         frac_in, frac_ff;
   logic             frac_valid_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         prod_lo_in[c] = NUM_W'(in_blend.lo[c]) * NUM_W'(in_blend.wlo);
         prod_hi_in[c] = NUM_W'(in_blend.hi[c]) * NUM_W'(in_blend.whi);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else if (en) begin
         prod_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_lo_ff <= prod_lo_in;
         prod_hi_ff <= prod_hi_in;
         div_ff     <= in_blend.div;
      end
   end

   // The sum stays below 2^32: the weights add up to the divisor.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         frac_in.num[c] = prod_lo_ff[c] + prod_hi_ff[c] + NUM_W'(div_ff >> 1);
      end
      frac_in.div = div_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frac_valid_ff <= 1'b0;
      end else if (en) begin
         frac_valid_ff <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         frac_ff <= frac_in;
      end
   end

   assign out_valid = frac_valid_ff;
   assign out_frac  = frac_ff;

endmodule

>>> rtl/crp_div.sv
// Pipelined restoring divider, one quotient bit per stage for all three channels.
// Depends on crp_pkg.
module crp_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  crp_pkg::frac_type   in_frac,
   output logic                out_valid,
   output crp_pkg::color_type  out_quot
);
   import crp_pkg::*;

   localparam int QUO_W = CHAN_W;

   num_type [2:0]    rem_ff [QUO_W];
   color_type        quo_ff [QUO_W];
   logic [POS_W-1:0] div_ff [QUO_W];
   logic [QUO_W-1:0] valid_ff;

   for (genvar s = 0; s < QUO_W; s++) begin : g_stage
      localparam int BIT = QUO_W - 1 - s;

      num_type [2:0]    src_rem, rem_in;
      color_type        src_quo, quo_in;
      logic [POS_W-1:0] src_div;
      logic             src_valid;
      num_type          div_shift;

      if (s == 0) begin : g_first
         assign src_rem   = in_frac.num;
         assign src_quo   = '0;
         assign src_div   = in_frac.div;
         assign src_valid = in_valid;
      end else begin : g_next
         assign src_rem   = rem_ff[s-1];
         assign src_quo   = quo_ff[s-1];
         assign src_div   = div_ff[s-1];
         assign src_valid = valid_ff[s-1];
      end

      // The numerator is below 2^16 times the divisor, so sixteen bits suffice.
      always_comb begin
         div_shift = NUM_W'(src_div) << BIT;
         for (int c = 0; c < 3; c++) begin
            if (src_rem[c] >= div_shift) begin
               rem_in[c] = src_rem[c] - div_shift;
               quo_in[c] = {src_quo[c][QUO_W-2:0], 1'b1};
            end else begin
               rem_in[c] = src_rem[c];
               quo_in[c] = {src_quo[c][QUO_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= rem_in;
            quo_ff[s] <= quo_in;
            div_ff[s] <= src_div;
         end
      end
   end

   assign out_valid = valid_ff[QUO_W-1];
   assign out_quot  = quo_ff[QUO_W-1];

endmodule

>>> rtl/color_ramp_interpolator_top.sv
// Top level of the color ramp interpolator: configuration registers, pipeline, output skid.
// Depends on crp_pkg, crp_select, crp_mac and crp_div.
//
// The block maps a signed Q1.14 ramp position to an RGB color (unsigned Q0.16 per
// channel) taken from a gradient of up to NUM_STOPS stops. It accepts one request
// every clock cycle while req_stall is low. Each color passes through the selection
// of the enclosing stop pair, the per-channel multiply and add, the pipelined divider
// that produces one quotient bit per stage, and the output register. Positions at or
// below the first stop return the first color, positions at or above the last active
// stop return that stop's color, and a pair of stops with equal positions returns the
// lower stop's color. Between two stops the blend rounds to nearest with ties up.
// Stops are written through the csr_ port (index 0 is the stop count, indexes 1 and
// up are the stop words); the user must write them only while no request is in
// flight, as the block itself does not enforce it. A stalled result waits in the
// output register while the pipeline keeps moving; a second result is caught in a
// one-entry skid stage, and only then does req_stall rise.
module color_ramp_interpolator_top #(
   parameter int NUM_STOPS = 6
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [crp_pkg::POS_W-1:0]     req_position,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [crp_pkg::CHAN_W-1:0]           rsp_red,
   output logic [crp_pkg::CHAN_W-1:0]           rsp_green,
   output logic [crp_pkg::CHAN_W-1:0]           rsp_blue,
   input  logic                                 csr_write_en,
   input  logic [crp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [crp_pkg::CSR_DATA_W-1:0]       csr_data
);
   import crp_pkg::*;

   // Configuration registers.
   logic [COUNT_W-1:0]          stop_count_ff;
   stop_type [NUM_STOPS-1:0]    stops_ff;

   // Pipeline enable: everything advances unless the skid stage holds a result.
   logic      pipe_en;
   logic      sel_valid, mac_valid, div_valid;
   blend_type sel_blend;
   frac_type  mac_frac;
   color_type div_quot;

   // Output register and skid stage.
   logic      out_valid_ff, skid_valid_ff;
   color_type out_color_ff, skid_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_count_ff <= COUNT_RESET;
         stops_ff      <= '0;
      end else if (csr_write_en) begin
         if (csr_index == CSR_STOP_COUNT) begin
            stop_count_ff <= csr_data[COUNT_W-1:0];
         end
         // Stop indexes past NUM_STOPS and unknown indexes match nothing and are dropped.
         for (int k = 0; k < NUM_STOPS; k++) begin
            if (csr_index == CSR_STOP_FIRST + CSR_IDX_W'(k)) begin
               stops_ff[k] <= stop_type'(csr_data);
            end
         end
      end
   end

   assign pipe_en   = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   crp_select #(
      .NUM_STOPS (NUM_STOPS)
   ) u_select (
      .clock       (clock),
      .reset       (reset),
      .en          (pipe_en),
      .in_valid    (req_valid),
      .in_position (req_position),
      .stops       (stops_ff),
      .stop_count  (stop_count_ff),
      .out_valid   (sel_valid),
      .out_blend   (sel_blend)
   );

   crp_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (sel_valid),
      .in_blend  (sel_blend),
      .out_valid (mac_valid),
      .out_frac  (mac_frac)
   );

   crp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (mac_valid),
      .in_frac   (mac_frac),
      .out_valid (div_valid),
      .out_quot  (div_quot)
   );

   // When the output register is taken, the skid entry moves up first; the skid stage
   // only fills when a new result arrives while the output register is stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_valid_ff && !rsp_stall) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= div_valid;
         end
      end else if (out_valid_ff) begin
         if (pipe_en && div_valid) begin
            skid_valid_ff <= 1'b1;
         end
      end else begin
         out_valid_ff <= pipe_en && div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_valid_ff && !rsp_stall) begin
         if (skid_valid_ff) begin
            out_color_ff <= skid_color_ff;
         end else begin
            out_color_ff <= div_quot;
         end
      end else if (out_valid_ff) begin
         if (pipe_en && div_valid) begin
            skid_color_ff <= div_quot;
         end
      end else begin
         out_color_ff <= div_quot;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_red   = out_color_ff[CH_RED];
   assign rsp_green = out_color_ff[CH_GREEN];
   assign rsp_blue  = out_color_ff[CH_BLUE];

endmodule

>>> tb/color_ramp_interpolator_top_tb.sv
// Self-checking testbench of color_ramp_interpolator_top: directed gradients, random gradients
// and output backpressure, with every color checked against a predictor in this file.
// Depends on crp_pkg and the RTL of color_ramp_interpolator_top.
`timescale 1ns / 100ps

module color_ramp_interpolator_top_tb;
   import crp_pkg::*;

   localparam int NUM_STOPS   = 6;
   localparam int LATENCY     = 21;
   localparam int SETTLE      = LATENCY + 4;
   localparam int HOLD_CYCLES = 200;
   localparam int CYCLE_LIMIT = 500000;

   // Index past the end of the register list; a write there must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   // Notable ramp positions in signed Q1.14.
   localparam logic [POS_W-1:0] POS_MOST_NEG = 16'h8000;
   localparam logic [POS_W-1:0] POS_MOST_POS = 16'h7fff;
   localparam logic [POS_W-1:0] POS_MINUS_ONE = 16'hc000;
   localparam logic [POS_W-1:0] POS_PLUS_ONE = 16'h4000;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rgb_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic signed [POS_W-1:0]     req_position = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [CHAN_W-1:0]           rsp_red;
   logic [CHAN_W-1:0]           rsp_green;
   logic [CHAN_W-1:0]           rsp_blue;
   logic                        csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]        csr_index = '0;
   logic [CSR_DATA_W-1:0]       csr_data = '0;

   // Shadow copy of the gradient registers, updated at every register write.
   logic [COUNT_W-1:0]          ramp_count = COUNT_RESET;
   logic [CSR_DATA_W-1:0]       ramp_stops [NUM_STOPS];

   // Colors predicted for accepted requests, oldest first.
   rgb_type                     pending_colors [$];

   int                          error_count = 0;
   int                          cycle_count = 0;

   // Switches for random idling on the request and result sides, and the
   // request for one long hold-off of the result channel.
   bit                          tx_idle_on = 1'b1;
   bit                          rx_idle_on = 1'b1;
   bit                          hold_request = 1'b0;

   color_ramp_interpolator_top #(
      .NUM_STOPS(NUM_STOPS)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_position(req_position),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_red     (rsp_red),
      .rsp_green   (rsp_green),
      .rsp_blue    (rsp_blue),
      .csr_write_en(csr_write_en),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Predictor of the ramp.
   // ---------------------------------------------------------------------------

   // Position of stop k, sign-extended from its Q1.14 field.
   function automatic int stop_pos(input int k);
      logic signed [POS_W-1:0] p;
      p = ramp_stops[k][63:48];
      return p;
   endfunction

   // Color of stop k; red sits highest in the stop word, as in rgb_type.
   function automatic rgb_type stop_rgb(input int k);
      return rgb_type'(ramp_stops[k][47:0]);
   endfunction

   // Weighted blend of one channel, rounded to nearest with ties going up.
   function automatic logic [CHAN_W-1:0] blend_chan(input longint unsigned lo_c,
                                                    input longint unsigned hi_c,
                                                    input longint unsigned span,
                                                    input longint unsigned offs);
      return CHAN_W'((lo_c * (span - offs) + hi_c * offs + span / 2) / span);
   endfunction

   function automatic rgb_type ramp_color(input logic signed [POS_W-1:0] pos);
      int               active;
      int               t;
      int               ta;
      int               tb;
      int               k;
      longint unsigned  span;
      longint unsigned  offs;
      rgb_type          lo;
      rgb_type          hi;
      rgb_type          res;
      // The stop count saturates into the range the hardware supports.
      active = ramp_count;
      if (active < COUNT_MIN) active = COUNT_MIN;
      if (active > NUM_STOPS) active = NUM_STOPS;
      t = pos;
      res = '0;
      if (t <= stop_pos(0)) return stop_rgb(0);
      if (t >= stop_pos(active - 1)) return stop_rgb(active - 1);
      // The first pair from the bottom that encloses the position wins, which
      // also settles unsorted gradients. No enclosing pair gives black.
      for (k = 0; k + 1 < active; k++) begin
         ta = stop_pos(k);
         tb = stop_pos(k + 1);
         if (ta <= t && t <= tb) begin
            // Two stops at one position give the lower stop's color.
            if (ta == tb) return stop_rgb(k);
            span = tb - ta;
            offs = t - ta;
            lo = stop_rgb(k);
            hi = stop_rgb(k + 1);
            res.red   = blend_chan(lo.red, hi.red, span, offs);
            res.green = blend_chan(lo.green, hi.green, span, offs);
            res.blue  = blend_chan(lo.blue, hi.blue, span, offs);
            return res;
         end
      end
      return res;
   endfunction

   // ---------------------------------------------------------------------------
   // Result side: random stall bursts, one long hold-off on demand, and the
   // comparison of every accepted result with the oldest prediction.
   // ---------------------------------------------------------------------------

   always begin
      @(posedge clock);
      if (hold_request) begin
         // Hold the results back long enough for the pipeline and its skid
         // stage to fill, so that req_stall has to rise.
         rsp_stall <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         rsp_stall <= 1'b0;
         hold_request = 1'b0;
      end else if (rx_idle_on && !reset && $urandom_range(0, 7) == 0) begin
         rsp_stall <= 1'b1;
         repeat ($urandom_range(1, 13)) @(posedge clock);
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : check_results
      rgb_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_colors.size() == 0) begin
            $error("color with no request outstanding: red %h green %h blue %h",
                   rsp_red, rsp_green, rsp_blue);
            error_count++;
         end else begin
            want = pending_colors.pop_front();
            if (rsp_red !== want.red) begin
               $error("red mismatch: expected %h, actual %h", want.red, rsp_red);
               error_count++;
            end
            if (rsp_green !== want.green) begin
               $error("green mismatch: expected %h, actual %h", want.green, rsp_green);
               error_count++;
            end
            if (rsp_blue !== want.blue) begin
               $error("blue mismatch: expected %h, actual %h", want.blue, rsp_blue);
               error_count++;
            end
         end
      end
   end

   // A hung pipeline must not stall the regression forever.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("color_ramp_interpolator_top regression: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Shared driving tasks.
   // ---------------------------------------------------------------------------

   // Writes one register and mirrors the write into the predictor. The enable
   // drops for a cycle between writes so it never sees two updates in one step.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == CSR_STOP_COUNT)
         ramp_count = data[COUNT_W-1:0];
      else if (idx >= CSR_STOP_FIRST && idx < CSR_STOP_FIRST + NUM_STOPS)
         ramp_stops[idx - CSR_STOP_FIRST] = data;
      @(posedge clock);
   endtask

   function automatic logic [CSR_DATA_W-1:0] stop_word(input int pos, input logic [CHAN_W-1:0] r,
                                                       input logic [CHAN_W-1:0] g,
                                                       input logic [CHAN_W-1:0] b);
      return {POS_W'(pos), r, g, b};
   endfunction

   // Offers one request and returns at the edge that accepts it. Valid stays
   // high afterwards so back-to-back requests run at full rate.
   task automatic send_request(input logic [POS_W-1:0] pos);
      if (tx_idle_on && $urandom_range(0, 5) == 0) begin
         req_valid    <= 1'b0;
         req_position <= POS_W'($urandom);
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_position <= pos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_colors.push_back(ramp_color(pos));
   endtask

   // Stops offering requests and waits until every color has come back, so the
   // registers can be rewritten with nothing in flight.
   task automatic settle_pipeline();
      req_valid <= 1'b0;
      while (pending_colors.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic [CHAN_W-1:0] rand_chan();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return CHAN_W'($urandom);
      endcase
   endfunction

   // Random positions: nominal range, any bit pattern, close to a stop where
   // the blend changes pair, and the extremes of the field.
   function automatic logic [POS_W-1:0] pick_position();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel <= 2) return POS_W'($urandom);
      if (sel <= 5) return POS_W'(int'($urandom_range(0, 32768)) - 16384);
      if (sel <= 8)
         return POS_W'(stop_pos($urandom_range(0, NUM_STOPS - 1)) + int'($urandom_range(0, 6)) - 3);
      case ($urandom_range(0, 3))
         0:       return POS_MOST_NEG;
         1:       return POS_MOST_POS;
         2:       return POS_MINUS_ONE;
         default: return POS_PLUS_ONE;
      endcase
   endfunction

   // Loads a random gradient. Most are sorted; some carry a duplicate stop,
   // some are left unsorted, and some span the whole position range.
   task automatic load_random_ramp();
      int                      spots [NUM_STOPS];
      int                      style;
      int                      i;
      int                      j;
      int                      tmp;
      logic signed [POS_W-1:0] wide;
      logic [CSR_DATA_W-1:0]   count_word;
      style = $urandom_range(0, 9);
      for (i = 0; i < NUM_STOPS; i++) begin
         wide = POS_W'($urandom);
         spots[i] = (style == 9) ? int'(wide) : int'($urandom_range(0, 40000)) - 20000;
      end
      if (style != 8) begin
         for (i = 0; i < NUM_STOPS - 1; i++)
            for (j = 0; j < NUM_STOPS - 1 - i; j++)
               if (spots[j] > spots[j + 1]) begin
                  tmp = spots[j];
                  spots[j] = spots[j + 1];
                  spots[j + 1] = tmp;
               end
      end
      if (style == 7) begin
         j = $urandom_range(0, NUM_STOPS - 2);
         spots[j + 1] = spots[j];
      end
      if (style == 9) begin
         spots[0] = -32768;
         spots[NUM_STOPS - 1] = 32767;
      end
      // The upper bits of the count word are junk that the block must drop.
      count_word = {$urandom, $urandom};
      count_word[COUNT_W-1:0] = COUNT_W'($urandom_range(0, 7));
      write_reg(CSR_STOP_COUNT, count_word);
      for (i = 0; i < NUM_STOPS; i++)
         write_reg(CSR_IDX_W'(CSR_STOP_FIRST + i),
                   stop_word(spots[i], rand_chan(), rand_chan(), rand_chan()));
      if ($urandom_range(0, 3) == 0) write_reg(CSR_UNUSED, {$urandom, $urandom});
   endtask

   // ---------------------------------------------------------------------------
   // Tests.
   // ---------------------------------------------------------------------------

   // Out of reset every stop is black at position zero and two stops are used.
   task automatic test_reset_defaults();
      send_request(POS_MINUS_ONE);
      send_request('0);
      send_request(POS_MOST_POS);
      settle_pipeline();
   endtask

   // Two stops from minus one to plus one, probed at and beyond both ends and
   // on either side of zero, where the blend rounds.
   task automatic test_two_stop_blend();
      write_reg(CSR_STOP_COUNT, COUNT_MIN);
      write_reg(CSR_STOP_FIRST, stop_word(-16384, 16'h0000, 16'hffff, 16'h1234));
      write_reg(CSR_IDX_W'(CSR_STOP_FIRST + 1), stop_word(16384, 16'hffff, 16'h0000, 16'habcd));
      send_request(POS_MOST_NEG);
      send_request(POS_MINUS_ONE);
      send_request(16'hffff);
      send_request(16'h0001);
      send_request(POS_PLUS_ONE);
      send_request(POS_MOST_POS);
      settle_pipeline();
   endtask

   // Two stops at the same position in the middle of the gradient.
   task automatic test_duplicate_stops();
      write_reg(CSR_STOP_COUNT, 3'd4);
      write_reg(CSR_STOP_FIRST, stop_word(-8000, 16'h1111, 16'h2222, 16'h3333));
      write_reg(CSR_IDX_W'(CSR_STOP_FIRST + 1), stop_word(0, 16'h4444, 16'h5555, 16'h6666));
      write_reg(CSR_IDX_W'(CSR_STOP_FIRST + 2), stop_word(0, 16'h7777, 16'h8888, 16'h9999));
      write_reg(CSR_IDX_W'(CSR_STOP_FIRST + 3), stop_word(8000, 16'haaaa, 16'hbbbb, 16'hcccc));
      send_request(16'h0000);
      send_request(16'hffff);
      send_request(16'h0001);
      settle_pipeline();
   endtask

   // Stops out of order: the lowest enclosing pair decides.
   task automatic test_unsorted_stops();
      write_reg(CSR_STOP_COUNT, 3'd3);
      write_reg(CSR_STOP_FIRST, stop_word(-1000, 16'hf000, 16'h0f00, 16'h00f0));
      write_reg(CSR_IDX_W'(CSR_STOP_FIRST + 1), stop_word(1000, 16'h000f, 16'hf0f0, 16'h0f0f));
      write_reg(CSR_IDX_W'(CSR_STOP_FIRST + 2), stop_word(-500, 16'h5a5a, 16'ha5a5, 16'hffff));
      send_request(POS_W'(-600));
      send_request(16'h0000);
      send_request(POS_W'(-2000));
      settle_pipeline();
   endtask

   // Stop counts below two and above the number of stops saturate.
   task automatic test_stop_count_limits();
      int                    i;
      int                    raw;
      logic [CSR_DATA_W-1:0] junk;
      for (i = 0; i < NUM_STOPS; i++)
         write_reg(CSR_IDX_W'(CSR_STOP_FIRST + i),
                   stop_word(-12000 + 5000 * i, CHAN_W'(i * 16'h2a00), CHAN_W'(16'hffff - i),
                             CHAN_W'(16'h0101 * (i + 1))));
      for (i = 0; i < 5; i++) begin
         case (i)
            0:       raw = 0;
            1:       raw = 1;
            2:       raw = 7;
            3:       raw = NUM_STOPS;
            default: raw = 3;
         endcase
         junk = {$urandom, $urandom};
         junk[COUNT_W-1:0] = COUNT_W'(raw);
         write_reg(CSR_STOP_COUNT, junk);
         send_request(POS_W'(8000));
         send_request(POS_W'(-9000));
         settle_pipeline();
      end
   endtask

   // A write past the end of the register list leaves the gradient alone.
   task automatic test_unused_register();
      write_reg(CSR_UNUSED, '1);
      send_request(16'hffff);
      send_request(16'h0001);
      settle_pipeline();
   endtask

   // Random gradients with random positions, idling switched per phase.
   task automatic test_random_ramps();
      int phase;
      int n;
      for (phase = 0; phase < 16; phase++) begin
         tx_idle_on = ($urandom_range(0, 3) != 0);
         rx_idle_on = ($urandom_range(0, 3) != 0);
         load_random_ramp();
         for (n = 0; n < 55; n++) send_request(pick_position());
         settle_pipeline();
      end
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
   endtask

   // The result channel is held off while requests keep coming at full rate.
   task automatic test_output_backpressure();
      int n;
      load_random_ramp();
      tx_idle_on = 1'b0;
      hold_request = 1'b1;
      for (n = 0; n < 80; n++) send_request(pick_position());
      settle_pipeline();
      tx_idle_on = 1'b1;
   endtask

   // Closing stretch at full rate with no idling on either side.
   task automatic test_steady_stream();
      int n;
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      load_random_ramp();
      for (n = 0; n < 150; n++) send_request(pick_position());
      settle_pipeline();
   endtask

   initial begin
      for (int k = 0; k < NUM_STOPS; k++) ramp_stops[k] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_two_stop_blend();
      test_duplicate_stops();
      test_unsorted_stops();
      test_stop_count_limits();
      test_unused_register();
      test_random_ramps();
      test_output_backpressure();
      test_steady_stream();

      // Allow a pipeline's worth of cycles for any stray result to show up.
      repeat (LATENCY) @(posedge clock);
      if (error_count == 0)
         $display("color_ramp_interpolator_top regression: pass");
      else
         $display("color_ramp_interpolator_top regression: fail");
      $finish;
   end

endmodule

>>> sim.f
rtl/crp_pkg.sv
rtl/crp_select.sv
rtl/crp_mac.sv
rtl/crp_div.sv
rtl/color_ramp_interpolator_top.sv
tb/color_ramp_interpolator_top_tb.sv
